// File: rtl/hfcd_pkg.sv
package hfcd_pkg;

  // ring geometry (depth is a power of two, positions wrap by truncation)
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;
  typedef logic [3:0]       cnt_t;

  // framing characters
  localparam byte_t CH_HASH = 8'h23;
  localparam byte_t CH_LF   = 8'h0A;
  localparam byte_t CH_ZERO = 8'h30;
  localparam byte_t CH_NINE = 8'h39;

  // '#', digit and command come before the payload
  localparam int HDR_LEN = 3;

  // ring entry offsets from the frame start
  localparam ptr_t OFS_DIGIT = ptr_t'(1);
  localparam ptr_t OFS_CMD   = ptr_t'(2);
  localparam ptr_t OFS_DATA  = ptr_t'(HDR_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_CMD,
    ST_EMIT,
    ST_SCAN
  } state_t;

  // ring write request from the sequencer
  typedef struct packed {
    logic  en;
    ptr_t  addr;
    byte_t data;
  } ring_wr_t;

endpackage

// File: rtl/hfcd_if.sv
// received byte channel
interface hfcd_rx_if;
  import hfcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded command channel
interface hfcd_cmd_if;
  import hfcd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t cmd_code;
  cnt_t  data_count;
  logic  has_data;
  byte_t data_byte;
  cnt_t  data_index;
  logic  last;
  modport source (output valid, output cmd_code, output data_count, output has_data,
                  output data_byte, output data_index, output last, input ready);
  modport sink   (input valid, input cmd_code, input data_count, input has_data,
                  input data_byte, input data_index, input last, output ready);
endinterface

// File: rtl/hfcd_ring.sv
module hfcd_ring
  import hfcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ring_wr_t wr,
  input  ptr_t     rd_addr,
  output byte_t    rd_data
);

  byte_t entry [RING_DEPTH];

  // byte store, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        entry[k] <= '0;
      end
    end else if (wr.en) begin
      entry[wr.addr] <= wr.data;
    end
  end

  // single read port
  assign rd_data = entry[rd_addr];

endmodule

// File: rtl/hfcd_seq.sv
module hfcd_seq
  import hfcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  hfcd_rx_if.sink       rx,
  hfcd_cmd_if.source    cmd,
  output ring_wr_t      ring_wr,
  output ptr_t          rd_addr,
  input  byte_t         rd_data
);

  state_t state, state_next;

  ptr_t  write_pos;
  ptr_t  lf_pos;
  logic  mark_pending;
  ptr_t  mark_pos;
  ptr_t  frame_pos;
  ptr_t  scan_pos;
  logic  from_mark;
  cnt_t  frame_n;
  byte_t frame_cmd;
  cnt_t  emit_idx;

  logic  out_valid;
  byte_t out_cmd;
  cnt_t  out_count;
  logic  out_has;
  byte_t out_byte;
  cnt_t  out_idx;
  logic  out_last;

  logic  accept;
  logic  digit_ok;
  cnt_t  digit_n;
  ptr_t  end_pos;
  logic  frame_ok;
  ptr_t  fail_pos;
  logic  emit_last;
  logic  load;
  ptr_t  addr_base;
  ptr_t  addr_ofs;

  assign accept = rx.valid && rx.ready;
  assign rx.ready = (state == ST_IDLE);

  // ring write of every accepted byte
  assign ring_wr.en   = accept;
  assign ring_wr.addr = write_pos;
  assign ring_wr.data = rx.rx_byte;

  // shared position adder feeding the ring read port
  always_comb begin
    addr_base = frame_pos;
    addr_ofs  = '0;
    case (state)
      ST_DIGIT: addr_ofs = OFS_DIGIT;
      ST_CMD:   addr_ofs = OFS_CMD;
      ST_EMIT:  addr_ofs = ptr_t'(OFS_DATA + ptr_t'(emit_idx));
      ST_SCAN:  addr_base = scan_pos;
      default:  addr_ofs = '0;
    endcase
  end
  assign rd_addr = ptr_t'(addr_base + addr_ofs);

  // digit and length check at the candidate frame start
  always_comb begin
    digit_ok = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
    digit_n  = cnt_t'(rd_data - CH_ZERO);
    end_pos  = ptr_t'(frame_pos + ptr_t'(digit_n) + ptr_t'(HDR_LEN));
    frame_ok = digit_ok && (end_pos == lf_pos);
    // scan_pos already points one entry below a failed search candidate
    fail_pos = from_mark ? ptr_t'(lf_pos - ptr_t'(2)) : scan_pos;
  end

  assign emit_last = (frame_n == '0) || (cnt_t'(emit_idx + cnt_t'(1)) == frame_n);
  assign load      = (state == ST_EMIT) && (!out_valid || cmd.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && rx.rx_byte == CH_LF && mark_pending) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (frame_ok) begin
          state_next = ST_CMD;
        end else if (fail_pos == mark_pos) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_CMD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (rd_data == CH_HASH) begin
          state_next = ST_DIGIT;
        end else if (ptr_t'(scan_pos - ptr_t'(1)) == mark_pos) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring pointers and mark
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      mark_pending <= 1'b0;
      mark_pos     <= '0;
    end else begin
      if (accept) begin
        write_pos <= ptr_t'(write_pos + ptr_t'(1));
        if (rx.rx_byte == CH_HASH && !mark_pending) begin
          mark_pending <= 1'b1;
          mark_pos     <= write_pos;
        end
      end
      if (state == ST_DIGIT && frame_ok) begin
        mark_pending <= 1'b0;
      end
    end
  end

  // search and frame context
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lf_pos    <= write_pos;
        frame_pos <= mark_pos;
        from_mark <= 1'b1;
      end
      ST_DIGIT: begin
        frame_n  <= digit_n;
        emit_idx <= '0;
        scan_pos <= fail_pos;
      end
      ST_CMD: frame_cmd <= rd_data;
      ST_EMIT: begin
        if (load) begin
          emit_idx <= cnt_t'(emit_idx + cnt_t'(1));
        end
      end
      ST_SCAN: begin
        frame_pos <= scan_pos;
        from_mark <= 1'b0;
        scan_pos  <= ptr_t'(scan_pos - ptr_t'(1));
      end
      default: from_mark <= from_mark;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd   <= frame_cmd;
      out_count <= frame_n;
      out_has   <= (frame_n != '0);
      out_byte  <= (frame_n != '0) ? rd_data : '0;
      out_idx   <= emit_idx;
      out_last  <= emit_last;
    end
  end

  assign cmd.valid      = out_valid;
  assign cmd.cmd_code   = out_cmd;
  assign cmd.data_count = out_count;
  assign cmd.has_data   = out_has;
  assign cmd.data_byte  = out_byte;
  assign cmd.data_index = out_idx;
  assign cmd.last       = out_last;

endmodule

// File: rtl/hash_framed_command_deframer.sv
// Deframer for '#', digit N, command, N data bytes, line feed. Each received
// byte is written into a 16-entry ring; a byte that is not a line feed, or a
// line feed with no pending '#' mark, needs no further work and the next byte
// can be taken right away. A line feed with a mark pending starts the
// sequencer, which reads the ring through one port: it checks the candidate at
// a frame start, then steps backward over the ring one entry at a time to
// search for another '#'. A match then reads the command byte and loads one
// result per data byte (N, or one for an empty frame), each waiting on the
// result side's ready. rx.ready is low until the last result has been loaded
// into the output register.
module hash_framed_command_deframer
  import hfcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hfcd_rx_if.sink    rx,
  hfcd_cmd_if.source cmd
);

  ring_wr_t ring_wr;
  ptr_t     rd_addr;
  byte_t    rd_data;

  hfcd_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr      (ring_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hfcd_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .cmd     (cmd),
    .ring_wr (ring_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/hfcd_checker.sv
module hfcd_checker
  import hfcd_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  rx_ready,
  input logic  cmd_valid,
  input logic  cmd_ready,
  input byte_t cmd_code,
  input cnt_t  data_count,
  input logic  has_data,
  input byte_t data_byte,
  input cnt_t  data_index,
  input logic  last
);

  // a result holds until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("result dropped before taken");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> $stable(cmd_code) && $stable(data_byte)
      && $stable(data_index) && $stable(last))
    else $error("stalled result changed");

  // no new byte while a frame is still being emitted
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !last |-> !rx_ready)
    else $error("byte accepted mid frame");

  // empty frame result shape
  a_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !has_data |-> last && data_count == '0 && data_byte == '0
      && data_index == '0)
    else $error("bad empty frame result");

  // payload index inside the frame
  a_index: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && has_data |-> data_index < data_count
      && (last == (cnt_t'(data_index + cnt_t'(1)) == data_count)))
    else $error("payload index out of frame");

endmodule

bind hash_framed_command_deframer hfcd_checker u_hfcd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_ready   (rx.ready),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_code   (cmd.cmd_code),
  .data_count (cmd.data_count),
  .has_data   (cmd.has_data),
  .data_byte  (cmd.data_byte),
  .data_index (cmd.data_index),
  .last       (cmd.last)
);
